FILE: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash set package
// Shared types, command and status codes, and state machine encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

   localparam logic [1:0] CMD_FIND     = 2'd0;
   localparam logic [1:0] CMD_INSERT   = 2'd1;
   localparam logic [1:0] CMD_DELETE   = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam logic [2:0] STATUS_HIT      = 3'd0;
   localparam logic [2:0] STATUS_MISS     = 3'd1;
   localparam logic [2:0] STATUS_INSERTED = 3'd2;
   localparam logic [2:0] STATUS_PRESENT  = 3'd3;
   localparam logic [2:0] STATUS_FULL     = 3'd4;

   localparam int KEY_W = 32;
   localparam logic [4:0] DIV_LAST = 5'd31;

   localparam logic [1:0] REG_BUCKET_COUNT = 2'd0;

   typedef struct packed {
      logic [1:0]       command;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [KEY_W-1:0] echo_key;
   } rsp_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_HEAD,
      BACK_LOOK,
      BACK_CMP,
      BACK_DECIDE,
      BACK_ALLOC,
      BACK_UNLINK
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/chs_front.sv
// ----------------------------------------------------------------------------
// Chained hash set front end
// Accepts a request and computes its bucket by a bit-serial modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_front import chs_pkg::*; #(
   parameter int MAX_BUCKETS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire req_type                            req_data,
   input  wire logic [6:0]                         bucket_count,
   output logic                                    q_push,
   input  wire logic                               q_full,
   output logic [$bits(req_type)+$clog2(MAX_BUCKETS)-1:0] q_data
);

   localparam int BW = $clog2(MAX_BUCKETS);
   localparam int RW = BW + 1;

   front_state_type  state_ff, state_in;
   req_type          req_ff, req_in;
   logic [KEY_W-1:0] shift_ff, shift_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW-1:0]    div_ff, div_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [RW-1:0]    trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff   <= req_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      q_push   = 1'b0;
      req_full = (state_ff != FRONT_IDLE);
      trial    = {rem_ff[RW-2:0], shift_ff[KEY_W-1]};
      case (state_ff)
         FRONT_IDLE: begin
            if (req_push) begin
               req_in   = req_data;
               shift_in = req_data.key;
               rem_in   = '0;
               cnt_in   = '0;
               // Clamp the divisor into the supported range of bucket counts.
               if (bucket_count < 7'd2) begin
                  div_in = RW'(2);
               end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
                  div_in = RW'(MAX_BUCKETS);
               end else begin
                  div_in = RW'(32'(bucket_count));
               end
               state_in = FRONT_DIV;
            end
         end
         FRONT_DIV: begin
            if (trial >= div_ff) begin
               rem_in = trial - div_ff;
            end else begin
               rem_in = trial;
            end
            shift_in = {shift_ff[KEY_W-2:0], 1'b0};
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   assign q_data = {req_ff, rem_ff[BW-1:0]};

endmodule

`default_nettype wire

FILE: rtl/chs_queue.sv
// ----------------------------------------------------------------------------
// Chained hash set queue
// Two-entry queue between the front end and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_queue #(
   parameter int WIDTH = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rdata = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ (push & !full);
      rptr_in  = rptr_ff ^ (pop & !empty);
      count_in = count_ff + {1'b0, push & !full} - {1'b0, pop & !empty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push && !full) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/chs_back.sv
// ----------------------------------------------------------------------------
// Chained hash set table engine
// Walks a bucket chain and carries out find, insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_back import chs_pkg::*; #(
   parameter int MAX_BUCKETS = 64,
   parameter int POOL_NODES  = 256
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       q_empty,
   output logic                                            q_pop,
   input  wire logic [$bits(req_type)+$clog2(MAX_BUCKETS)-1:0] q_data,
   output logic                                            rsp_empty,
   input  wire logic                                       rsp_pop,
   output rsp_type                                         rsp_data
);

   localparam int BW = $clog2(MAX_BUCKETS);
   localparam int AW = $clog2(POOL_NODES);
   localparam int NW = $clog2(POOL_NODES + 1);
   localparam logic [NW-1:0] EMPTY = NW'(POOL_NODES);

   back_state_type   state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [BW-1:0]    bkt_ff, bkt_in;
   logic [NW-1:0]    cur_ff, cur_in;
   logic [NW-1:0]    prev_ff, prev_in;
   logic [NW-1:0]    head_ff, head_in;
   logic [NW-1:0]    hlink_ff, hlink_in;
   logic [NW-1:0]    free_ff, free_in;
   logic [NW-1:0]    fresh_ff, fresh_in;
   logic [BW-1:0]    clr_ff, clr_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rvalid_ff, rvalid_in;

   logic [NW-1:0]    head_mem [MAX_BUCKETS];
   logic [KEY_W-1:0] key_mem [POOL_NODES];
   logic [NW-1:0]    link_mem [POOL_NODES];
   logic [NW-1:0]    head_rd_ff;
   logic [KEY_W-1:0] key_rd_ff;
   logic [NW-1:0]    link_rd_ff;

   logic             hd_we;
   logic [BW-1:0]    hd_waddr, hd_raddr;
   logic [NW-1:0]    hd_wdata;
   logic             key_we, link_we;
   logic [AW-1:0]    nd_waddr, lk_waddr, nd_raddr;
   logic [NW-1:0]    lk_wdata;
   req_type          q_req;
   logic             hit;

   assign q_req     = q_data[$bits(q_data)-1 -: $bits(req_type)];
   assign hit       = (cur_ff != EMPTY);
   assign rsp_empty = !rvalid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (hd_we) begin
         head_mem[hd_waddr] <= hd_wdata;
      end
      head_rd_ff <= head_mem[hd_raddr];
      if (key_we) begin
         key_mem[nd_waddr] <= key_ff;
      end
      key_rd_ff <= key_mem[nd_raddr];
      if (link_we) begin
         link_mem[lk_waddr] <= lk_wdata;
      end
      link_rd_ff <= link_mem[nd_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_CLEAR;
         clr_ff    <= '0;
         free_ff   <= EMPTY;
         fresh_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         free_ff   <= free_in;
         fresh_ff  <= fresh_in;
         rvalid_ff <= rvalid_in;
      end
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      bkt_ff   <= bkt_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      head_ff  <= head_in;
      hlink_ff <= hlink_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      bkt_in    = bkt_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      head_in   = head_ff;
      hlink_in  = hlink_ff;
      free_in   = free_ff;
      fresh_in  = fresh_ff;
      clr_in    = clr_ff;
      rsp_in    = rsp_ff;
      rvalid_in = rvalid_ff & !rsp_pop;
      q_pop     = 1'b0;
      hd_we     = 1'b0;
      hd_waddr  = bkt_ff;
      hd_wdata  = EMPTY;
      hd_raddr  = bkt_ff;
      key_we    = 1'b0;
      link_we   = 1'b0;
      nd_waddr  = fresh_ff[AW-1:0];
      lk_waddr  = fresh_ff[AW-1:0];
      lk_wdata  = head_ff;
      nd_raddr  = cur_ff[AW-1:0];
      case (state_ff)
         BACK_CLEAR: begin
            hd_we    = 1'b1;
            hd_waddr = clr_ff;
            clr_in   = clr_ff + BW'(1);
            if (clr_ff == BW'(MAX_BUCKETS - 1)) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            // A transaction starts only once the previous result has left.
            if (!q_empty && !rvalid_ff) begin
               q_pop    = 1'b1;
               cmd_in   = q_req.command;
               key_in   = q_req.key;
               bkt_in   = q_data[BW-1:0];
               hd_raddr = q_data[BW-1:0];
               state_in = BACK_HEAD;
            end
         end
         BACK_HEAD: begin
            cur_in   = head_rd_ff;
            head_in  = head_rd_ff;
            prev_in  = EMPTY;
            state_in = BACK_LOOK;
         end
         BACK_LOOK: begin
            if (cur_ff == EMPTY) begin
               state_in = BACK_DECIDE;
            end else begin
               state_in = BACK_CMP;
            end
         end
         BACK_CMP: begin
            if (key_rd_ff == key_ff) begin
               hlink_in = link_rd_ff;
               state_in = BACK_DECIDE;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rd_ff;
               state_in = BACK_LOOK;
            end
         end
         BACK_DECIDE: begin
            case (cmd_ff)
               CMD_INSERT: begin
                  if (hit) begin
                     rsp_in    = '{status: STATUS_PRESENT, echo_key: key_ff};
                     rvalid_in = 1'b1;
                     state_in  = BACK_IDLE;
                  end else if (free_ff != EMPTY) begin
                     nd_raddr = free_ff[AW-1:0];
                     state_in = BACK_ALLOC;
                  end else if (fresh_ff < NW'(POOL_NODES)) begin
                     key_we    = 1'b1;
                     link_we   = 1'b1;
                     hd_we     = 1'b1;
                     hd_wdata  = fresh_ff;
                     fresh_in  = fresh_ff + NW'(1);
                     rsp_in    = '{status: STATUS_INSERTED, echo_key: key_ff};
                     rvalid_in = 1'b1;
                     state_in  = BACK_IDLE;
                  end else begin
                     rsp_in    = '{status: STATUS_FULL, echo_key: key_ff};
                     rvalid_in = 1'b1;
                     state_in  = BACK_IDLE;
                  end
               end
               CMD_DELETE: begin
                  if (!hit) begin
                     rsp_in    = '{status: STATUS_MISS, echo_key: key_ff};
                     rvalid_in = 1'b1;
                     state_in  = BACK_IDLE;
                  end else begin
                     if (prev_ff == EMPTY) begin
                        hd_we    = 1'b1;
                        hd_wdata = hlink_ff;
                     end else begin
                        link_we  = 1'b1;
                        lk_waddr = prev_ff[AW-1:0];
                        lk_wdata = hlink_ff;
                     end
                     state_in = BACK_UNLINK;
                  end
               end
               default: begin
                  rsp_in    = '{status: (hit ? STATUS_HIT : STATUS_MISS),
                                echo_key: key_ff};
                  rvalid_in = 1'b1;
                  state_in  = BACK_IDLE;
               end
            endcase
         end
         BACK_ALLOC: begin
            // The released node's link holds the next node of the free list.
            free_in   = link_rd_ff;
            key_we    = 1'b1;
            link_we   = 1'b1;
            nd_waddr  = free_ff[AW-1:0];
            lk_waddr  = free_ff[AW-1:0];
            hd_we     = 1'b1;
            hd_wdata  = free_ff;
            rsp_in    = '{status: STATUS_INSERTED, echo_key: key_ff};
            rvalid_in = 1'b1;
            state_in  = BACK_IDLE;
         end
         BACK_UNLINK: begin
            link_we   = 1'b1;
            lk_waddr  = cur_ff[AW-1:0];
            lk_wdata  = free_ff;
            free_in   = cur_ff;
            rsp_in    = '{status: STATUS_HIT, echo_key: key_ff};
            rvalid_in = 1'b1;
            state_in  = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NW'(POOL_NODES))
      else $error("fresh node count beyond the pool");

   a_free_used: assert property (@(posedge clock) disable iff (reset)
      (free_ff == EMPTY) || (free_ff < fresh_ff))
      else $error("free list head names a node never handed out");

   a_start_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_HEAD) |-> $past(q_pop))
      else $error("chain walk started without a queued transaction");
`endif

endmodule

`default_nettype wire

FILE: rtl/chained_hash_set.sv
// ----------------------------------------------------------------------------
// Chained hash set
// A set of 32-bit keys in a hash table with separate chaining.
// ----------------------------------------------------------------------------
// Requests (command and key) enter on the req_ queue port: push with full
// low. Each request gives exactly one result (status and key) on the rsp_
// queue port, shown while empty is low and taken with pop.
// The front end computes key modulo the bucket count one bit per cycle.
// The table engine reads the bucket head, then looks at each chain node
// and compares its key until one matches or the chain ends, then decides;
// an insert from the free list goes on to an allocate step and a delete
// to an unlink step. The two overlap through a two-entry queue, so the
// throughput is set by the slower of the two.
// A result waits in an output register until popped; while it waits the
// engine holds, and the front end keeps taking requests until the queue
// fills. After reset the engine clears the bucket heads, during which
// requests are accepted and queued but not executed.
// bucket_count sits at byte address 0 of the csr_ port and resets to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_set import chs_pkg::*; #(
   parameter int MAX_BUCKETS = 64,
   parameter int POOL_NODES  = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire req_type     req_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int QW = $bits(req_type) + $clog2(MAX_BUCKETS);

   logic [6:0]    bcount_ff, bcount_in;
   logic          q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_BUCKET_COUNT) ? {25'd0, bcount_ff} : 32'd0;

   always_comb begin
      bcount_in = bcount_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_BUCKET_COUNT) begin
         bcount_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff <= 7'd64;
      end else begin
         bcount_ff <= bcount_in;
      end
   end

   chs_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .bucket_count (bcount_ff),
      .q_push       (q_push),
      .q_full       (q_full),
      .q_data       (q_wdata)
   );

   chs_queue #(.WIDTH(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .wdata (q_wdata),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   chs_back #(.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/chained_hash_set_tb.sv
// ----------------------------------------------------------------------------
// Chained hash set testbench
// Drives find, insert, delete and reserved requests through the queue ports with random
// idling on both sides, predicts every status from an internal copy of the
// table, and checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class chs_scoreboard;
   localparam int NBUCK = 64;
   localparam int NPOOL = 256;
   localparam int NIL   = NPOOL;

   int unsigned head_idx [NBUCK];
   logic [31:0] node_key [NPOOL];
   int unsigned node_next [NPOOL];
   int unsigned free_idx;
   int unsigned fresh_cnt;
   logic [6:0]  buckets;
   chs_pkg::rsp_type pending [$];
   int unsigned errors;

   function new();
      for (int i = 0; i < NBUCK; i++) head_idx[i] = NIL;
      for (int i = 0; i < NPOOL; i++) begin
         node_key[i] = '0;
         node_next[i] = 0;
      end
      free_idx = NIL;
      fresh_cnt = 0;
      buckets = 7'd64;
      errors = 0;
   endfunction

   function void set_buckets(logic [6:0] v);
      buckets = v;
   endfunction

   function int unsigned nodes_held();
      int unsigned n;
      int unsigned p;
      n = fresh_cnt;
      p = free_idx;
      while (p != NIL) begin
         n--;
         p = node_next[p];
      end
      return n;
   endfunction

   // Works out the status of one accepted request and updates the table.
   function void note_request(chs_pkg::req_type r);
      int unsigned nb;
      int unsigned b;
      int unsigned cur;
      int unsigned prv;
      int unsigned steps;
      int unsigned n;
      chs_pkg::rsp_type e;
      nb = buckets < 2 ? 2 : (buckets > NBUCK ? NBUCK : buckets);
      b = r.key % nb;
      cur = head_idx[b];
      prv = NIL;
      steps = 0;
      while (cur != NIL && steps < NPOOL && node_key[cur] != r.key) begin
         prv = cur;
         cur = node_next[cur];
         steps++;
      end
      if (steps >= NPOOL) cur = NIL;
      e.echo_key = r.key;
      if (r.command == chs_pkg::CMD_INSERT) begin
         if (cur != NIL) e.status = chs_pkg::STATUS_PRESENT;
         else begin
            if (free_idx != NIL) begin
               n = free_idx;
               free_idx = node_next[n];
            end else if (fresh_cnt < NPOOL) begin
               n = fresh_cnt;
               fresh_cnt++;
            end else n = NIL;
            if (n == NIL) e.status = chs_pkg::STATUS_FULL;
            else begin
               node_key[n] = r.key;
               node_next[n] = head_idx[b];
               head_idx[b] = n;
               e.status = chs_pkg::STATUS_INSERTED;
            end
         end
      end else if (r.command == chs_pkg::CMD_DELETE) begin
         if (cur == NIL) e.status = chs_pkg::STATUS_MISS;
         else begin
            if (prv == NIL) head_idx[b] = node_next[cur];
            else node_next[prv] = node_next[cur];
            node_next[cur] = free_idx;
            free_idx = cur;
            e.status = chs_pkg::STATUS_HIT;
         end
      end else begin
         e.status = (cur != NIL) ? chs_pkg::STATUS_HIT : chs_pkg::STATUS_MISS;
      end
      pending.push_back(e);
   endfunction

   function void check_result(chs_pkg::rsp_type got);
      chs_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected result: status %0d key %h", got.status, got.echo_key);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, got.status);
         errors++;
      end
      if (got.echo_key !== e.echo_key) begin
         $error("echo_key: expected %h, actual %h", e.echo_key, got.echo_key);
         errors++;
      end
   endfunction
endclass

module chained_hash_set_tb;
   import chs_pkg::*;

   localparam int LIMIT = 5_000_000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   chs_scoreboard board;
   int unsigned   push_idle_pct;
   int unsigned   pop_idle_pct;
   int unsigned   cycles;
   logic [31:0]   key_pool [16];

   chained_hash_set dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side: random stalls, every accepted transaction is checked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) board.check_result(rsp_data);
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("chained_hash_set test failed");
         $finish;
      end
   end

   // push stays high between back-to-back transactions and drops only to idle.
   task automatic send(logic [1:0] cmd, logic [31:0] k);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{command: cmd, key: k};
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request('{command: cmd, key: k});
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_buckets(logic [6:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_BUCKET_COUNT;
      csr_pwdata  <= {25'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_buckets(v);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return key_pool[$urandom_range(15)];
      endcase
   endfunction

   task automatic random_phase(int unsigned count);
      int unsigned c;
      for (int i = 0; i < count; i++) begin
         c = $urandom_range(99);
         if (board.nodes_held() > 200 && c < 50) c = 80;
         if (c < 40) send(CMD_INSERT, pick_key());
         else if (c < 65) send(CMD_FIND, pick_key());
         else if (c < 97) send(CMD_DELETE, pick_key());
         else send(CMD_RESERVED, pick_key());
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycles = 0;
      push_idle_pct = 32;
      pop_idle_pct = 82;
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every command, duplicates and the unknown command.
      send(CMD_FIND, 32'h0);
      send(CMD_INSERT, 32'h0);
      send(CMD_INSERT, 32'h0);
      send(CMD_INSERT, 32'hFFFF_FFFF);
      send(CMD_INSERT, 32'd64);
      send(CMD_INSERT, 32'd128);
      send(CMD_FIND, 32'd64);
      send(CMD_RESERVED, 32'hFFFF_FFFF);
      send(CMD_DELETE, 32'd64);
      send(CMD_DELETE, 32'd64);
      send(CMD_DELETE, 32'h0);
      send(CMD_INSERT, 32'hAAAA_5555);
      send(CMD_INSERT, 32'h5555_AAAA);
      send(CMD_FIND, 32'd128);
      drain();

      // Out-of-range settings clamp; old chains stay put under a new count.
      write_buckets(7'd0);
      send(CMD_FIND, 32'd128);
      send(CMD_INSERT, 32'd128);
      send(CMD_INSERT, 32'd3);
      send(CMD_INSERT, 32'd5);
      drain();
      write_buckets(7'd127);
      send(CMD_FIND, 32'd3);
      send(CMD_DELETE, 32'd128);
      drain();

      // Exhaust the pool with fresh nodes, then reuse released ones.
      write_buckets(7'd2);
      for (int i = 0; i < 260; i++) send(CMD_INSERT, 32'h1000_0000 + i);
      for (int i = 0; i < 20; i++) send(CMD_DELETE, 32'h1000_0000 + i * 3);
      for (int i = 0; i < 22; i++) send(CMD_INSERT, 32'h2000_0000 + i);
      drain();
      for (int i = 0; i < 260; i++) send(CMD_DELETE, 32'h1000_0000 + i);
      for (int i = 0; i < 22; i++) send(CMD_DELETE, 32'h2000_0000 + i);
      drain();

      write_buckets(7'd7);
      random_phase(350);
      drain();
      push_idle_pct = 82;
      pop_idle_pct = 32;
      write_buckets(7'd64);
      random_phase(350);
      drain();
      push_idle_pct = 0;
      pop_idle_pct = 0;
      write_buckets(7'd1);
      random_phase(150);
      drain();
      write_buckets(7'd33);
      random_phase(250);
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("chained_hash_set test passed");
      else
         $display("chained_hash_set test failed");
      $finish;
   end
endmodule

`default_nettype wire
